// ===== sv/cbsp_pkg.sv =====
`default_nettype none

package cbsp_pkg;

    // widths fixed by the word fields
    localparam int COORD_W  = 24;
    localparam int U_W      = 17;
    localparam int CNT_W    = 5;
    localparam int DEG_W    = 2;
    localparam int T_W      = 21;   // u * spans, at most 31 * 65536
    localparam int W_W      = 33;   // basis weight, Q1.32 up to 1.0
    localparam int DVD_W    = 54;   // weight * distance + half divisor
    localparam int PROD_W   = 59;
    localparam int ACC_W    = 57;
    localparam int KIDX_W   = 7;
    localparam int DIV_STEPS = 33;

    localparam logic [U_W-1:0] U_ONE   = 17'h10000;
    localparam logic [W_W-1:0] W_ONE   = 33'h1_0000_0000;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_SETUP = 11'b000_0000_0010,
        ST_MUL   = 11'b000_0000_0100,
        ST_LOAD  = 11'b000_0000_1000,
        ST_DIV   = 11'b000_0001_0000,
        ST_UPD   = 11'b000_0010_0000,
        ST_RD    = 11'b000_0100_0000,
        ST_MX    = 11'b000_1000_0000,
        ST_MY    = 11'b001_0000_0000,
        ST_MZ    = 11'b010_0000_0000,
        ST_DONE  = 11'b100_0000_0000
    } state_t;

    // clamped uniform knot j, scaled to 1/65536 of a span
    function automatic logic [T_W-1:0] knot_scaled(
        input logic [KIDX_W-1:0] idx,
        input logic [DEG_W-1:0]  deg,
        input logic [CNT_W-1:0]  spans
    );
        logic signed [KIDX_W+1:0] v;
        logic [CNT_W-1:0]         vc;
        v  = $signed({2'b00, idx}) - $signed({{(KIDX_W){1'b0}}, deg});
        if (v < 0)
            vc = '0;
        else if (v > $signed({{(KIDX_W+2-CNT_W){1'b0}}, spans}))
            vc = spans;
        else
            vc = v[CNT_W-1:0];
        return {vc, 16'h0000};
    endfunction

    // round half up, then limit to the coordinate range
    function automatic logic [COORD_W-1:0] round_coord(input logic signed [ACC_W-1:0] s);
        logic signed [ACC_W:0]  b;
        logic signed [25:0]     q;
        b = {s[ACC_W-1], s} + $signed({{(ACC_W-31){1'b0}}, 32'h8000_0000});
        q = b[ACC_W:32];
        if (q > 26'sd8388607)
            return 24'h7F_FFFF;
        else if (q < -26'sd8388608)
            return 24'h80_0000;
        else
            return q[COORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/clamped_bspline_point_eval.sv =====
// clamped uniform b-spline point evaluator
//
// input stream: s_axis_tuser selects the word kind. a write word stores one
// control point in the point table and gives no output word. an evaluate
// word brings param_u and gives one curve point on the output stream,
// status in m_axis_tuser.
// s_axis_tready is high only while the sequencer is idle. an evaluate word
// runs on one shared multiplier and one radix-2 divider: after setup, each
// of the degree*(degree+1)/2 basis splits runs multiply, load, 33 divide
// steps and update, and the weighted sum reads each control point and
// multiplies and accumulates x, y and z, then rounds and hands over.
// a count not above the degree is answered with status 1.
// the result sits in an output register; the next word is taken while it
// waits, and a finished result waits in the done state until the register
// is free. config writes go on the plain write port; the user must make
// them only while idle, the block itself does not enforce it.
// reset clears control state and restores count 4, degree 3; the point
// table holds nothing defined until written.
`default_nettype none

module clamped_bspline_point_eval #(
    parameter int MAX_POINTS = 16,
    parameter int MAX_DEGREE = 3
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_addr,
    input  wire logic [4:0]  cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // point_index, in_x, in_y, in_z, param_u, zero fill
    input  wire logic [95:0] s_axis_tdata,
    // op
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_x, out_y, out_z
    output logic [71:0]      m_axis_tdata,
    // status
    output logic             m_axis_tuser
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam logic [cbsp_pkg::CNT_W-1:0] CNT_CAP =
        (MAX_POINTS > 31) ? 5'd31 : 5'(MAX_POINTS);
    localparam logic [cbsp_pkg::DEG_W-1:0] DEG_CAP =
        (MAX_DEGREE > 3) ? 2'd3 : 2'(MAX_DEGREE);
    localparam int WN = int'(DEG_CAP) + 1;
    localparam int WI = (WN > 1) ? $clog2(WN) : 1;

    localparam logic CFG_COUNT  = 1'b0;
    localparam logic CFG_DEGREE = 1'b1;

    cbsp_pkg::state_t state_reg, state_next;

    logic [cbsp_pkg::CNT_W-1:0] point_count_reg;
    logic [cbsp_pkg::DEG_W-1:0] curve_degree_reg;

    logic [3*cbsp_pkg::COORD_W-1:0] mem [MAX_POINTS];
    logic [3*cbsp_pkg::COORD_W-1:0] rd_data_reg;

    logic [cbsp_pkg::U_W-1:0]    u_reg;
    logic [cbsp_pkg::T_W-1:0]    t_reg;
    logic [cbsp_pkg::CNT_W-1:0]  k_reg;
    logic [cbsp_pkg::KIDX_W-1:0] s_reg;
    logic [1:0]                  j_reg;
    logic [1:0]                  r_reg;
    logic [1:0]                  jj_reg;
    logic                        err_reg;
    logic [cbsp_pkg::W_W-1:0]    w_reg [WN];
    logic [cbsp_pkg::W_W-1:0]    carry_reg;
    logic signed [cbsp_pkg::PROD_W-1:0] prod_reg;
    logic [cbsp_pkg::T_W-1:0]    d_reg;
    logic [cbsp_pkg::T_W-1:0]    rem_reg;
    logic [cbsp_pkg::DIV_STEPS-1:0] low_reg;
    logic [5:0]                  dcnt_reg;
    logic signed [cbsp_pkg::ACC_W-1:0] accx_reg, accy_reg, accz_reg;

    logic                        out_valid_reg;
    logic [71:0]                 out_data_reg;
    logic                        out_status_reg;

    // derived configuration
    logic [cbsp_pkg::CNT_W-1:0] cnt;
    logic [cbsp_pkg::DEG_W-1:0] deg;
    logic [cbsp_pkg::CNT_W-1:0] spans;
    assign cnt   = (point_count_reg > CNT_CAP) ? CNT_CAP : point_count_reg;
    assign deg   = (curve_degree_reg > DEG_CAP) ? DEG_CAP : curve_degree_reg;
    assign spans = cnt - {3'b000, deg};

    // input fields
    logic                        in_op;
    logic [3:0]                  in_index;
    logic [cbsp_pkg::U_W-1:0]    in_u;
    assign in_op    = s_axis_tuser;
    assign in_index = s_axis_tdata[3:0];
    assign in_u     = s_axis_tdata[92:76];

    logic in_fire, out_fire, out_free;
    assign s_axis_tready = (state_reg == cbsp_pkg::ST_IDLE);
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = out_valid_reg && m_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    // span lookup
    logic [cbsp_pkg::T_W-1:0]   t_calc;
    logic [cbsp_pkg::CNT_W-1:0] k_calc;
    assign t_calc = {4'd0, u_reg} * {16'd0, spans};
    assign k_calc = (t_calc[cbsp_pkg::T_W-1:16] > spans - 5'd1) ? spans - 5'd1
                                                                 : t_calc[cbsp_pkg::T_W-1:16];

    // knot distances for the current split
    logic [cbsp_pkg::T_W-1:0] knot_hi, knot_lo, rgt, lft, d_calc;
    assign knot_hi = cbsp_pkg::knot_scaled(s_reg + 7'(r_reg) + 7'd1, deg, spans);
    assign knot_lo = cbsp_pkg::knot_scaled(s_reg + 7'(r_reg) + 7'd1 - 7'(j_reg), deg, spans);
    assign rgt     = knot_hi - t_reg;
    assign lft     = t_reg - knot_lo;
    assign d_calc  = rgt + lft;

    // shared multiplier
    logic [cbsp_pkg::W_W-1:0]            w_sel;
    logic signed [cbsp_pkg::W_W:0]       mul_a;
    logic signed [cbsp_pkg::COORD_W:0]   mul_b;
    logic signed [cbsp_pkg::PROD_W-1:0]  mul_p;
    assign w_sel = (state_reg == cbsp_pkg::ST_MUL) ? w_reg[r_reg[WI-1:0]]
                                                    : w_reg[jj_reg[WI-1:0]];
    assign mul_a = $signed({1'b0, w_sel});
    always_comb
    begin
        unique case (state_reg)
            cbsp_pkg::ST_MX: mul_b = $signed({rd_data_reg[23], rd_data_reg[23:0]});
            cbsp_pkg::ST_MY: mul_b = $signed({rd_data_reg[47], rd_data_reg[47:24]});
            cbsp_pkg::ST_MZ: mul_b = $signed({rd_data_reg[71], rd_data_reg[71:48]});
            default:         mul_b = $signed({4'b0000, rgt});
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // divider step
    logic [cbsp_pkg::DVD_W-1:0] dvd;
    logic [cbsp_pkg::T_W:0]     trial;
    logic                       ge;
    assign dvd   = prod_reg[cbsp_pkg::DVD_W-1:0] + {33'd0, 1'b0, d_reg[cbsp_pkg::T_W-1:1]};
    assign trial = {rem_reg, low_reg[cbsp_pkg::DIV_STEPS-1]};
    assign ge    = (trial >= {1'b0, d_reg});

    // split of one weight
    logic [cbsp_pkg::W_W-1:0] w_cur, split_b;
    logic                     last_r;
    assign w_cur   = w_reg[r_reg[WI-1:0]];
    assign split_b = w_cur - low_reg;
    assign last_r  = ({1'b0, r_reg} + 3'd1) == {1'b0, j_reg};

    // memory read address
    logic [6:0] rd_idx;
    assign rd_idx = {2'b00, k_reg} + {5'd0, jj_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cbsp_pkg::ST_IDLE:
            begin
                if (in_fire && in_op == cbsp_pkg::OP_EVAL)
                    state_next = (cnt <= {3'b000, deg}) ? cbsp_pkg::ST_DONE
                                                        : cbsp_pkg::ST_SETUP;
            end
            cbsp_pkg::ST_SETUP: state_next = (deg == 2'd0) ? cbsp_pkg::ST_RD
                                                           : cbsp_pkg::ST_MUL;
            cbsp_pkg::ST_MUL:   state_next = cbsp_pkg::ST_LOAD;
            cbsp_pkg::ST_LOAD:  state_next = cbsp_pkg::ST_DIV;
            cbsp_pkg::ST_DIV:
            begin
                if (dcnt_reg == 6'(cbsp_pkg::DIV_STEPS - 1))
                    state_next = cbsp_pkg::ST_UPD;
            end
            cbsp_pkg::ST_UPD:
                state_next = (last_r && j_reg == deg) ? cbsp_pkg::ST_RD : cbsp_pkg::ST_MUL;
            cbsp_pkg::ST_RD:    state_next = cbsp_pkg::ST_MX;
            cbsp_pkg::ST_MX:    state_next = cbsp_pkg::ST_MY;
            cbsp_pkg::ST_MY:    state_next = cbsp_pkg::ST_MZ;
            cbsp_pkg::ST_MZ:
                state_next = (jj_reg == deg) ? cbsp_pkg::ST_DONE : cbsp_pkg::ST_RD;
            cbsp_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = cbsp_pkg::ST_IDLE;
            end
            default:            state_next = cbsp_pkg::ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= cbsp_pkg::ST_IDLE;
            point_count_reg  <= 5'd4;
            curve_degree_reg <= 2'd3;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_addr)
                    CFG_COUNT:  point_count_reg  <= cfg_wdata;
                    CFG_DEGREE: curve_degree_reg <= cfg_wdata[1:0];
                    default:    ;
                endcase
            end
            if (state_reg == cbsp_pkg::ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_fire)
                out_valid_reg <= 1'b0;
        end
    end

    // point table
    always_ff @(posedge clk)
    begin
        if (in_fire && in_op == cbsp_pkg::OP_WRITE && int'(in_index) < MAX_POINTS)
            mem[AW'(in_index)] <= s_axis_tdata[75:4];
        rd_data_reg <= mem[rd_idx[AW-1:0]];
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            cbsp_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    u_reg   <= (in_u > cbsp_pkg::U_ONE) ? cbsp_pkg::U_ONE : in_u;
                    err_reg <= (cnt <= {3'b000, deg});
                end
            end
            cbsp_pkg::ST_SETUP:
            begin
                t_reg     <= t_calc;
                k_reg     <= k_calc;
                s_reg     <= {2'b00, k_calc} + {5'd0, deg};
                j_reg     <= 2'd1;
                r_reg     <= 2'd0;
                jj_reg    <= 2'd0;
                carry_reg <= '0;
                accx_reg  <= '0;
                accy_reg  <= '0;
                accz_reg  <= '0;
                for (int i = 0; i < WN; i++)
                    w_reg[i] <= (i == 0) ? cbsp_pkg::W_ONE : '0;
            end
            cbsp_pkg::ST_MUL:
            begin
                prod_reg <= mul_p;
                d_reg    <= d_calc;
            end
            cbsp_pkg::ST_LOAD:
            begin
                // top bits stay below the divisor since the quotient fits 33 bits
                rem_reg  <= dvd[cbsp_pkg::DVD_W-1:cbsp_pkg::DIV_STEPS];
                low_reg  <= dvd[cbsp_pkg::DIV_STEPS-1:0];
                dcnt_reg <= '0;
            end
            cbsp_pkg::ST_DIV:
            begin
                rem_reg  <= ge ? cbsp_pkg::T_W'(trial - {1'b0, d_reg})
                               : trial[cbsp_pkg::T_W-1:0];
                low_reg  <= {low_reg[cbsp_pkg::DIV_STEPS-2:0], ge};
                dcnt_reg <= dcnt_reg + 6'd1;
            end
            cbsp_pkg::ST_UPD:
            begin
                w_reg[r_reg[WI-1:0]] <= carry_reg + low_reg;
                if (last_r)
                begin
                    w_reg[j_reg[WI-1:0]] <= split_b;
                    carry_reg <= '0;
                    r_reg     <= 2'd0;
                    j_reg     <= j_reg + 2'd1;
                end
                else
                begin
                    carry_reg <= split_b;
                    r_reg     <= r_reg + 2'd1;
                end
            end
            cbsp_pkg::ST_MX: accx_reg <= accx_reg + mul_p[cbsp_pkg::ACC_W-1:0];
            cbsp_pkg::ST_MY: accy_reg <= accy_reg + mul_p[cbsp_pkg::ACC_W-1:0];
            cbsp_pkg::ST_MZ:
            begin
                accz_reg <= accz_reg + mul_p[cbsp_pkg::ACC_W-1:0];
                jj_reg   <= jj_reg + 2'd1;
            end
            cbsp_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    if (err_reg)
                    begin
                        out_data_reg   <= '0;
                        out_status_reg <= cbsp_pkg::STATUS_ERR;
                    end
                    else
                    begin
                        out_data_reg   <= {cbsp_pkg::round_coord(accz_reg),
                                           cbsp_pkg::round_coord(accy_reg),
                                           cbsp_pkg::round_coord(accx_reg)};
                        out_status_reg <= cbsp_pkg::STATUS_OK;
                    end
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

    // split never gives more than the weight it splits
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cbsp_pkg::ST_UPD) |-> (low_reg <= w_cur))
        else $error("basis split exceeds weight");

    // knot difference of a live split is at least one span
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cbsp_pkg::ST_DIV) |-> (d_reg >= 21'h10000))
        else $error("divisor below one span");

    // an error word carries a zero point
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == cbsp_pkg::STATUS_ERR) |-> (m_axis_tdata == '0))
        else $error("error word with nonzero point");

    // a new output word only comes from the done state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == cbsp_pkg::ST_DONE))
        else $error("output word without a finished evaluation");

endmodule

`default_nettype wire

// ===== tb/sv/clamped_bspline_point_eval_tb.sv =====
`timescale 1ns / 100ps

module clamped_bspline_point_eval_tb;

    localparam logic REG_COUNT  = 1'b0;
    localparam logic REG_DEGREE = 1'b1;
    localparam int   CYCLE_LIMIT = 2000000;
    localparam int   NUM_PHASES  = 11;
    localparam int   PHASE_ITEMS = 115;

    typedef struct packed {
        logic [cbsp_pkg::COORD_W-1:0] x;
        logic [cbsp_pkg::COORD_W-1:0] y;
        logic [cbsp_pkg::COORD_W-1:0] z;
        logic                         status;
    } curve_pt_t;

    typedef struct {
        logic                         op;
        logic [3:0]                   idx;
        logic [cbsp_pkg::COORD_W-1:0] x;
        logic [cbsp_pkg::COORD_W-1:0] y;
        logic [cbsp_pkg::COORD_W-1:0] z;
        logic [cbsp_pkg::U_W-1:0]     u;
        bit                           typed;
        curve_pt_t                    pt;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic        cfg_addr;
    logic [4:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tuser;

    clamped_bspline_point_eval dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // mirror of the block state
    logic signed [cbsp_pkg::COORD_W-1:0] table_x [16];
    logic signed [cbsp_pkg::COORD_W-1:0] table_y [16];
    logic signed [cbsp_pkg::COORD_W-1:0] table_z [16];
    logic [cbsp_pkg::CNT_W-1:0] cur_count;
    logic [cbsp_pkg::DEG_W-1:0] cur_degree;

    curve_pt_t pending_pts[$];
    int        mismatches;
    int        cycles;
    bit        calm;

    stim_row_t directed[$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void queue_row(stim_row_t row);
        directed.insert(directed.size(), row);
    endfunction

    function automatic longint unsigned knot_at(longint j, longint deg, longint spans);
        longint v;
        v = j - deg;
        if (v < 0) v = 0;
        if (v > spans) v = spans;
        return longint'(v) * 65536;
    endfunction

    function automatic logic [cbsp_pkg::COORD_W-1:0] round_sum(longint acc);
        longint q;
        q = (acc + (longint'(1) << 31)) >>> 32;
        if (q > 8388607) q = 8388607;
        if (q < -8388608) q = -8388608;
        return q[cbsp_pkg::COORD_W-1:0];
    endfunction

    function automatic curve_pt_t spline_point(logic [cbsp_pkg::U_W-1:0] u_in);
        curve_pt_t         res;
        longint            cnt, deg, spans, k, s;
        longint unsigned   u, t, d, a, b, carry;
        longint unsigned   w[4];
        longint unsigned   lft[4];
        longint unsigned   rgt[4];
        longint            sx, sy, sz;
        res = '0;
        cnt = (cur_count > 16) ? 16 : cur_count;
        deg = cur_degree;
        if (cnt <= deg)
        begin
            res.status = cbsp_pkg::STATUS_ERR;
            return res;
        end
        spans = cnt - deg;
        u = (u_in > cbsp_pkg::U_ONE) ? 65536 : u_in;
        t = u * spans;
        k = t >> 16;
        if (k > spans - 1) k = spans - 1;
        s = k + deg;
        w[0] = longint'(1) << 32;
        for (int j = 1; j <= deg; j++)
        begin
            carry = 0;
            lft[j] = t - knot_at(s + 1 - j, deg, spans);
            rgt[j] = knot_at(s + j, deg, spans) - t;
            for (int r = 0; r < j; r++)
            begin
                d = rgt[r+1] + lft[j-r];
                a = (w[r] * rgt[r+1] + d / 2) / d;
                b = w[r] - a;
                w[r] = carry + a;
                carry = b;
            end
            w[j] = carry;
        end
        sx = 0; sy = 0; sz = 0;
        for (int j = 0; j <= deg; j++)
        begin
            sx += longint'(w[j]) * longint'(table_x[k+j]);
            sy += longint'(w[j]) * longint'(table_y[k+j]);
            sz += longint'(w[j]) * longint'(table_z[k+j]);
        end
        res.x = round_sum(sx);
        res.y = round_sum(sy);
        res.z = round_sum(sz);
        res.status = cbsp_pkg::STATUS_OK;
        return res;
    endfunction

    task automatic write_reg(logic addr, logic [4:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (addr == REG_COUNT)
            cur_count = val;
        else
            cur_degree = val[cbsp_pkg::DEG_W-1:0];
        @(posedge clk);
    endtask

    // drive one word, wait for acceptance, then log what it should produce
    task automatic send_word(stim_row_t row);
        if (!calm && $urandom_range(99) < 7)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= row.op;
        s_axis_tdata  <= {3'b000, row.u, row.z, row.y, row.x, row.idx};
        do @(posedge clk); while (!s_axis_tready);
        if (row.op == cbsp_pkg::OP_WRITE)
        begin
            table_x[row.idx] = row.x;
            table_y[row.idx] = row.y;
            table_z[row.idx] = row.z;
        end
        else if (row.typed)
            pending_pts.insert(pending_pts.size(), row.pt);
        else
            pending_pts.insert(pending_pts.size(), spline_point(row.u));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_pts.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    function automatic logic [cbsp_pkg::COORD_W-1:0] rand_coord();
        case ($urandom_range(9))
            0: return 24'h7F_FFFF;
            1: return 24'h80_0000;
            2: return 24'h00_0000;
            3: return 24'hFF_FFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic stim_row_t rand_row();
        stim_row_t row;
        row = '{default: '0};
        row.op  = ($urandom_range(99) < 40) ? cbsp_pkg::OP_WRITE : cbsp_pkg::OP_EVAL;
        row.idx = 4'($urandom_range(15));
        row.x   = rand_coord();
        row.y   = rand_coord();
        row.z   = rand_coord();
        case ($urandom_range(19))
            0, 1: row.u = '0;
            2, 3: row.u = cbsp_pkg::U_ONE;
            4:    row.u = 17'($urandom_range(131071, 65537));
            5:    row.u = 17'h1FFFF;
            default: row.u = 17'($urandom_range(65536));
        endcase
        return row;
    endfunction

    function automatic stim_row_t mk_write(int idx, int x, int y, int z);
        stim_row_t row;
        row = '{default: '0};
        row.op = cbsp_pkg::OP_WRITE;
        row.idx = 4'(idx);
        row.x = 24'(x); row.y = 24'(y); row.z = 24'(z);
        return row;
    endfunction

    function automatic stim_row_t mk_eval(int u, bit typed, curve_pt_t pt);
        stim_row_t row;
        row = '{default: '0};
        row.op = cbsp_pkg::OP_EVAL;
        row.u = 17'(u);
        row.typed = typed;
        row.pt = pt;
        return row;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        curve_pt_t got, want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata[23:0], m_axis_tdata[47:24], m_axis_tdata[71:48],
                       m_axis_tuser};
                if (pending_pts.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word x=%h y=%h z=%h st=%b",
                                 got.x, got.y, got.z, got.status);
                end
                else
                begin
                    want = pending_pts.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp x=%h y=%h z=%h st=%b got x=%h y=%h z=%h st=%b",
                                     want.x, want.y, want.z, want.status,
                                     got.x, got.y, got.z, got.status);
                    end
                end
            end
            m_axis_tready <= calm || ($urandom_range(99) >= 7);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int cnt_set [NUM_PHASES] = '{4, 16, 31, 2, 3, 5, 0, 1, 16, 9, 2};
        int deg_set [NUM_PHASES] = '{3, 3, 3, 1, 3, 0, 2, 0, 1, 2, 2};
        curve_pt_t none;
        none = '0;
        mismatches = 0;
        cycles = 0;
        calm = 1'b0;
        cur_count = 5'd4;
        cur_degree = 2'd3;
        for (int i = 0; i < 16; i++)
        begin
            table_x[i] = '0; table_y[i] = '0; table_z[i] = '0;
        end
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = 1'b0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;

        // every slot is written before the first evaluation
        queue_row(mk_write(0, 24'h7F_FFFF, 24'h80_0000, 24'h00_0000));
        queue_row(mk_write(1, 24'h80_0000, 24'h7F_FFFF, 24'h7F_FFFF));
        queue_row(mk_write(2, 24'h00_0000, 24'h80_0000, 24'h80_0000));
        queue_row(mk_write(3, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF));
        for (int i = 4; i < 16; i++)
            queue_row(mk_write(i, i * 1000, -i * 777, 24'h55_AAAA ^ i));
        queue_row(mk_eval(0, 1'b1, '{24'h7F_FFFF, 24'h80_0000, 24'h00_0000, 1'b0}));
        queue_row(mk_eval(65536, 1'b1, '{24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 1'b0}));
        // parameter past one is clamped to the end point
        queue_row(mk_eval(131071, 1'b1, '{24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 1'b0}));
        queue_row(mk_eval(32768, 1'b0, none));
        queue_row(mk_eval(1, 1'b0, none));
        queue_row(mk_write(15, 24'h12_3456, 24'hED_CBA9, 24'h00_0001));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_word(directed[i]);
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_reg(REG_COUNT, 5'(cnt_set[ph]));
            write_reg(REG_DEGREE, 5'(deg_set[ph]));
            calm = (ph == 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_word(rand_row());
            calm = 1'b0;
            wait_drained();
        end

        if (mismatches == 0 && pending_pts.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
sv/cbsp_pkg.sv
sv/clamped_bspline_point_eval.sv
tb/sv/clamped_bspline_point_eval_tb.sv
